[rtl/pvm_pkg.sv]
// Package: shared types and constants for the PCM voice mixer.
`timescale 1ns / 1ps
`default_nettype none
package pvm_pkg;
  localparam int VOICES = 8;
  localparam int VOICE_BITS = $clog2(VOICES);
  localparam int SAMPLE_ADDR_BITS = 16;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_MUSIC = 2'd1,
    KIND_SOUND = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] length;
    logic [15:0] position;
    logic [15:0] loop_first;
    logic [15:0] loop_limit;
    logic        loops;
  } voice_t;

  localparam logic signed [19:0] SAT_MAX = 20'sd32767;
  localparam logic signed [19:0] SAT_MIN = -20'sd32768;
endpackage
`default_nettype wire

[rtl/pcm_voice_mixer.sv]
// Top level: multi-voice 8-bit PCM playback mixer with a per-voice sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   load a sample byte, start music on voice 0, start a sound effect on
//   the first idle voice 1..7 (voice 1 is taken when all are busy), or tick.
//   Each tick yields one mixed_sample on the output channel (out_valid /
//   out_stall); other commands yield nothing.
//   Load and start leave the block idle, so it is ready for a new command
//   right after. A tick walks the voices one at a time, each through an
//   address state then an accumulate state (memory read through the single
//   read port of the sample RAM and the shared adder).
//   in_stall is high while a tick is being worked or while its result waits.
//   Receiver stall: mixed_sample holds in the output register until taken;
//   no new item is accepted until then.
//   Reset: all voices idle, saved music cleared. Sample memory content is
//   undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module pcm_voice_mixer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [15:0] sample_address,
  input  wire logic [7:0]  sample_byte,
  input  wire logic [15:0] sample_len,
  input  wire logic        loop_enable,
  input  wire logic [15:0] loop_first,
  input  wire logic [15:0] loop_limit,
  input  wire logic        interrupt_music,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] mixed_sample
);
  localparam int VB = pvm_pkg::VOICE_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADDR  = 4'b0010,
    ST_ACCUM = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state;
  pvm_pkg::voice_t voice [pvm_pkg::VOICES];
  logic [pvm_pkg::VOICES-1:0] active;
  pvm_pkg::voice_t saved;
  logic music_interrupted;
  logic [VB-1:0] vidx;
  logic fetched;
  logic signed [19:0] acc;
  logic [7:0] rdata;
  logic [pvm_pkg::SAMPLE_ADDR_BITS-1:0] raddr;

  logic accept;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);

  // Current voice after a possible resume of the saved music.
  pvm_pkg::voice_t cur;
  logic cur_resume;
  always_comb begin
    cur_resume = (vidx == '0) && music_interrupted &&
                 (voice[vidx].position >= voice[vidx].length);
    cur = cur_resume ? saved : voice[vidx];
  end

  assign raddr = pvm_pkg::SAMPLE_ADDR_BITS'(cur.base + cur.position);

  pvm_sample_ram u_ram (
    .clk  (clk),
    .we   (accept && kind == pvm_pkg::KIND_LOAD),
    .waddr(pvm_pkg::SAMPLE_ADDR_BITS'(sample_address)),
    .wdata(sample_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  // First idle sound voice; default voice 1.
  logic [VB-1:0] free_v;
  always_comb begin
    free_v = VB'(1);
    for (int i = pvm_pkg::VOICES - 1; i >= 1; i--) begin
      if (!active[i]) free_v = VB'(i);
    end
  end

  pvm_pkg::voice_t started;
  assign started = '{base: sample_address, length: sample_len, position: 16'd0,
                     loop_first: loop_first, loop_limit: loop_limit,
                     loops: loop_enable};

  logic [15:0] pos_inc;
  logic [15:0] pos_next;
  logic still_interrupted;
  assign pos_inc = cur.position + 16'd1;
  assign pos_next = (cur.loops && pos_inc >= cur.loop_limit) ? cur.loop_first : pos_inc;
  assign still_interrupted = (vidx == '0) && music_interrupted && !cur_resume;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
      music_interrupted <= 1'b0;
      vidx <= '0;
      fetched <= 1'b0;
      acc <= '0;
      saved <= '0;
      for (int i = 0; i < pvm_pkg::VOICES; i++) voice[i] <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (pvm_pkg::kind_t'(kind))
              pvm_pkg::KIND_LOAD: ;
              pvm_pkg::KIND_MUSIC: begin
                if (interrupt_music && active[0]) begin
                  saved <= voice[0];
                  music_interrupted <= 1'b1;
                end else begin
                  saved <= '0;
                  music_interrupted <= 1'b0;
                end
                voice[0] <= started;
                active[0] <= 1'b1;
              end
              pvm_pkg::KIND_SOUND: begin
                voice[free_v] <= started;
                active[free_v] <= 1'b1;
              end
              pvm_pkg::KIND_TICK: begin
                vidx <= '0;
                acc <= '0;
                state <= ST_ADDR;
              end
              default: ;
            endcase
          end
        end
        ST_ADDR: begin
          // Advance the voice state; memory read of raddr lands next cycle.
          fetched <= 1'b0;
          if (active[vidx]) begin
            if (cur_resume) music_interrupted <= 1'b0;
            if (cur.position < cur.length) begin
              fetched <= 1'b1;
              voice[vidx] <= '{base: cur.base, length: cur.length, position: pos_next,
                               loop_first: cur.loop_first, loop_limit: cur.loop_limit,
                               loops: cur.loops};
              if (pos_next >= cur.length && !still_interrupted) active[vidx] <= 1'b0;
            end else begin
              voice[vidx] <= cur;
              if (!still_interrupted) active[vidx] <= 1'b0;
            end
          end
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (fetched) acc <= acc + {{4{rdata[7]}}, rdata, 8'd0};
          if (vidx == VB'(pvm_pkg::VOICES - 1)) begin
            state <= ST_OUT;
          end else begin
            vidx <= vidx + VB'(1);
            state <= ST_ADDR;
          end
        end
        ST_OUT: begin
          if (!out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    if (acc > pvm_pkg::SAT_MAX) mixed_sample = 16'sh7FFF;
    else if (acc < pvm_pkg::SAT_MIN) mixed_sample = -16'sh8000;
    else mixed_sample = acc[15:0];
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("output valid while accepting input");
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == pvm_pkg::KIND_TICK) |=> (state == ST_ADDR && vidx == '0))
    else $error("tick did not start voice walk");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mixed_sample)))
    else $error("stalled result changed");
  a_music_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && music_interrupted) |-> active[0])
    else $error("interrupted music without active voice 0");
`endif
endmodule
`default_nettype wire

[rtl/pvm_sample_ram.sv]
// Sample memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pvm_sample_ram (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [pvm_pkg::SAMPLE_ADDR_BITS-1:0]  waddr,
  input  wire logic [7:0]                            wdata,
  input  wire logic [pvm_pkg::SAMPLE_ADDR_BITS-1:0]  raddr,
  output logic      [7:0]                            rdata
);
  logic [7:0] mem [0:(1 << pvm_pkg::SAMPLE_ADDR_BITS)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
